FILE: rtl/core/bad_pkg.sv
// Shared types and constants for the block average with deadband hold.
`timescale 1ns / 1ps
package bad_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 18;
  localparam int COUNT_W  = 8;
  localparam int DIVS_W   = COUNT_W + 1;
  localparam int BITCNT_W = $clog2(SUM_W + 1);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 1'b1;

  localparam logic [COUNT_W-1:0]  BLOCK_LENGTH_RST = 8'hff;
  localparam logic [SAMPLE_W-1:0] DEADBAND_RST     = 10'h00f;
  localparam logic [SAMPLE_W-1:0] MEAN_MAX         = 10'h3ff;
  localparam logic [DIVS_W-1:0]   FULL_BLOCK_DIVS  = 9'h100;

  typedef struct packed {
    logic start;
    logic clr;
  } ser_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

endpackage

FILE: rtl/core/bad_acc.sv
// Bit-serial accumulator: adds one sample into the running sum, LSB first.
`timescale 1ns / 1ps
module bad_acc
  import bad_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ser_ctrl_t           ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output ser_stat_t           stat_o,
  output logic [SUM_W-1:0]    sum_o
);

  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SUM_W-1:0]    add_q, add_d;
  logic                carry_q, carry_d;
  logic [BITCNT_W-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                bit_s;

  assign bit_s = sum_q[0] ^ add_q[0] ^ carry_q;

  always_comb begin
    sum_d   = sum_q;
    add_d   = add_q;
    carry_d = carry_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.start) begin
      add_d   = {{(SUM_W-SAMPLE_W){1'b0}}, sample_i};
      carry_d = 1'b0;
      cnt_d   = BITCNT_W'(SUM_W);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      sum_d   = {bit_s, sum_q[SUM_W-1:1]};
      add_d   = {1'b0, add_q[SUM_W-1:1]};
      carry_d = (sum_q[0] & add_q[0]) | (carry_q & (sum_q[0] ^ add_q[0]));
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == BITCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      carry_q <= 1'b0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      carry_q <= carry_d;
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    add_q <= add_d;
  end

  assign sum_o       = sum_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/bad_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bad_div
  import bad_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ser_ctrl_t         ctrl_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output ser_stat_t         stat_o,
  output logic [SUM_W-1:0]  quot_o
);

  logic [SUM_W-1:0]    dvd_q, dvd_d;
  logic [DIVS_W-1:0]   rem_q, rem_d;
  logic [DIVS_W-1:0]   dvs_q, dvs_d;
  logic [BITCNT_W-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIVS_W:0]     trial_s;
  logic [DIVS_W:0]     diff_s;
  logic                ge_s;

  assign trial_s = {rem_q, dvd_q[SUM_W-1]};
  assign ge_s    = trial_s >= {1'b0, dvs_q};
  assign diff_s  = trial_s - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = BITCNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[SUM_W-2:0], ge_s};
      rem_d = ge_s ? diff_s[DIVS_W-1:0] : trial_s[DIVS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == BITCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o      = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: rtl/core/block_average_deadband_top.sv
// Top level: block averaging with deadband hold on a held output value.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata[9:0] sample
//   m_axis    out  m_axis_tvalid/tready    tdata[9:0] held_value, tlast block_end,
//                                          tuser value_changed
//   cfg       in   cfg_we_i                cfg_idx_i, cfg_data_i
//
// An item is accepted, passes the bit-serial adder, waits for its done flag and is
// loaded into the output register. An item that closes a block also passes the
// bit-serial divider, waits for its done flag and takes the deadband compare.
// Reset clears count, sum, held value and sets block_length 255, deadband 15.
// A result waits in the output register while m_axis_tready is low; the next item
// is taken meanwhile and stalls only when its own result is ready to load.
`timescale 1ns / 1ps
module block_average_deadband_top
  import bad_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [9:0] sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [9:0] held_value
  output logic                  m_axis_tlast,   // block_end
  output logic                  m_axis_tuser,   // value_changed
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [COUNT_W-1:0]  blen_q;
  logic [SAMPLE_W-1:0] dband_q10;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [SAMPLE_W-1:0] held_q, held_d;
  logic                end_q, end_d;
  logic                chg_q, chg_d;
  logic                mvalid_q, mvalid_d;
  logic [SAMPLE_W-1:0] mdata_q;
  logic                mlast_q, muser_q;
  logic                load_out;

  ser_ctrl_t           acc_ctrl, div_ctrl;
  ser_stat_t           acc_stat, div_stat;
  logic [SUM_W-1:0]    sum_s, quot_s;
  logic [DIVS_W-1:0]   divisor_s;
  logic [COUNT_W-1:0]  count_inc;
  logic [SAMPLE_W-1:0] mean_s, absdiff_s;
  logic                accept;

  bad_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .stat_o   (acc_stat),
    .sum_o    (sum_s)
  );

  assign divisor_s = (blen_q == '0) ? FULL_BLOCK_DIVS : {1'b0, blen_q};

  bad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (sum_s),
    .divisor_i  (divisor_s),
    .stat_o     (div_stat),
    .quot_o     (quot_s)
  );

  assign count_inc = count_q + 1'b1;
  assign mean_s    = (|quot_s[SUM_W-1:SAMPLE_W]) ? MEAN_MAX : quot_s[SAMPLE_W-1:0];
  assign absdiff_s = (mean_s > held_q) ? (mean_s - held_q) : (held_q - mean_s);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == ST_OUT) && (!mvalid_q || m_axis_tready);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    held_d         = held_q;
    end_d          = end_q;
    chg_d          = chg_q;
    acc_ctrl.start = 1'b0;
    acc_ctrl.clr   = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.clr   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_ctrl.start = 1'b1;
          end_d          = (count_inc == blen_q);
          chg_d          = 1'b0;
          count_d        = (count_inc == blen_q) ? '0 : count_inc;
          state_d        = ST_ADD;
        end
      end
      ST_ADD: begin
        if (acc_stat.done) begin
          if (end_q) begin
            div_ctrl.start = 1'b1;
            state_d        = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        acc_ctrl.clr = 1'b1;
        if (absdiff_s > dband_q10) begin
          held_d = mean_s;
          chg_d  = 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mvalid_d = mvalid_q;
    if (load_out) begin
      mvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      mvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      blen_q    <= BLOCK_LENGTH_RST;
      dband_q10 <= DEADBAND_RST;
      count_q   <= '0;
      held_q    <= '0;
      end_q     <= 1'b0;
      chg_q     <= 1'b0;
      mvalid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      held_q   <= held_d;
      end_q    <= end_d;
      chg_q    <= chg_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BLOCK_LENGTH: blen_q    <= cfg_data_i[COUNT_W-1:0];
          REG_DEADBAND:     dband_q10 <= cfg_data_i[SAMPLE_W-1:0];
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      mdata_q <= held_q;
      mlast_q <= end_q;
      muser_q <= chg_q;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {{(16-SAMPLE_W){1'b0}}, mdata_q};
  assign m_axis_tlast  = mlast_q;
  assign m_axis_tuser  = muser_q;

  a_chg_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser || m_axis_tlast))
    else $error("value_changed without block_end");

  a_held_only_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_q) |-> ($past(state_q) == ST_CMP))
    else $error("held value moved outside the compare step");

  a_div_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (end_q && state_q == ST_DIV))
    else $error("divider running on an item that does not close a block");

  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!acc_stat.busy && !div_stat.busy))
    else $error("serial unit busy while taking a new sample");

endmodule
